// ===== design/apss_pkg.sv =====
// ----------------------------------------------------------------------------
// apss_pkg
// Shared types and constants of the ancestor path stack search unit:
// operation and status codes, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package apss_pkg;

  // default sizing of the stack
  localparam int unsigned MaxDepthDef = 1024;
  localparam int unsigned NodeBitsDef = 16;

  // fixed field widths of the stream items
  localparam int unsigned FuncBits   = 2;
  localparam int unsigned IdBits     = 16;
  localparam int unsigned AgeBits    = 31;
  localparam int unsigned StatusBits = 2;

  // input tdata layout: node_id, node_age, age_bound, padded to bytes
  localparam int unsigned InFieldBits = IdBits + AgeBits + AgeBits;
  localparam int unsigned InDataBits  = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned OutDataBits = IdBits;

  // operation codes
  localparam logic [FuncBits-1:0] FuncPush  = 2'd0;
  localparam logic [FuncBits-1:0] FuncPop   = 2'd1;
  localparam logic [FuncBits-1:0] FuncQuery = 2'd2;

  // status codes
  localparam logic [StatusBits-1:0] StatOk         = 2'd0;
  localparam logic [StatusBits-1:0] StatFull       = 2'd1;
  localparam logic [StatusBits-1:0] StatEmptyPop   = 2'd2;
  localparam logic [StatusBits-1:0] StatEmptyQuery = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StFetch,
    StHold
  } state_e;

  // one finished result
  typedef struct packed {
    logic [IdBits-1:0]     node;
    logic [StatusBits-1:0] status;
  } result_t;

endpackage

// ===== design/ancestor_path_stack_search_unit.sv =====
// ----------------------------------------------------------------------------
// ancestor_path_stack_search_unit
// Path stack of (node, age) pairs with push, pop and a binary search query
// for the first entry from the root whose age is at most a bound.
//
//   channel   dir  handshake                       payload
//   s_axis    in   s_axis_tvalid_i/s_axis_tready_o tuser func, tdata id/age/bound
//   m_axis    out  m_axis_tvalid_o/m_axis_tready_i tuser status, tdata found_node
//
// push, pop, unused code and errors: result registered at accept, next item
// taken in the following cycle unless the result has to be held (see below).
// query on a stack of n entries: a binary search that reads one entry a cycle
// through the single read port of the stack memory.
// reset clears the stack length, state and output valid; no clearing pass over the memory.
// a result waits in the output register; if a second one finishes while that
// is not taken, it is held and input stays stalled until the first leaves.
// ----------------------------------------------------------------------------
module ancestor_path_stack_search_unit #(
  parameter int unsigned MAX_DEPTH = apss_pkg::MaxDepthDef,
  parameter int unsigned NODE_BITS = apss_pkg::NodeBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input items
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [15:0] node_id, [46:16] node_age, [77:47] age_bound, [79:78] zero
  input  logic [apss_pkg::InDataBits-1:0]      s_axis_tdata_i,
  // [1:0] func
  input  logic [apss_pkg::FuncBits-1:0]        s_axis_tuser_i,
  // result items
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [15:0] found_node
  output logic [apss_pkg::OutDataBits-1:0]     m_axis_tdata_o,
  // [1:0] status
  output logic [apss_pkg::StatusBits-1:0]      m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned MW = apss_pkg::AgeBits + NODE_BITS;
  localparam int unsigned IB = apss_pkg::IdBits;
  localparam int unsigned AB = apss_pkg::AgeBits;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [MW-1:0]             mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [MW-1:0]             mem_rdata;
  apss_pkg::result_t         out_res;

  // sequencer
  apss_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .NODE_BITS (NODE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_node_i   (s_axis_tdata_i[IB-1:0]),
    .in_age_i    (s_axis_tdata_i[IB+AB-1:IB]),
    .in_bound_i  (s_axis_tdata_i[IB+2*AB-1:IB+AB]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // stack storage
  apss_stack_mem #(
    .DEPTH (MAX_DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata_o = out_res.node;
  assign m_axis_tuser_o = out_res.status;

endmodule

// ===== design/apss_stack_mem.sv =====
// ----------------------------------------------------------------------------
// apss_stack_mem
// Stack storage: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module apss_stack_mem #(
  parameter int unsigned DEPTH = apss_pkg::MaxDepthDef,
  parameter int unsigned WIDTH = apss_pkg::AgeBits + apss_pkg::NodeBitsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/apss_ctrl.sv =====
// ----------------------------------------------------------------------------
// apss_ctrl
// Sequencer of the path stack: keeps the stack length, runs push and pop,
// steps the binary search one memory read per cycle and holds the result.
// ----------------------------------------------------------------------------
module apss_ctrl #(
  parameter int unsigned MAX_DEPTH = apss_pkg::MaxDepthDef,
  parameter int unsigned NODE_BITS = apss_pkg::NodeBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // input items
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [apss_pkg::FuncBits-1:0]           in_func_i,
  input  logic [apss_pkg::IdBits-1:0]             in_node_i,
  input  logic [apss_pkg::AgeBits-1:0]            in_age_i,
  input  logic [apss_pkg::AgeBits-1:0]            in_bound_i,
  // result items
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output apss_pkg::result_t                       out_res_o,
  // stack memory
  output logic                                    mem_we_o,
  output logic [$clog2(MAX_DEPTH)-1:0]            mem_waddr_o,
  output logic [apss_pkg::AgeBits+NODE_BITS-1:0]  mem_wdata_o,
  output logic                                    mem_re_o,
  output logic [$clog2(MAX_DEPTH)-1:0]            mem_raddr_o,
  input  logic [apss_pkg::AgeBits+NODE_BITS-1:0]  mem_rdata_i
);

  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IB = apss_pkg::IdBits;

  apss_pkg::state_e                state_q, state_d;
  logic [LW-1:0]                   len_q, len_d;
  logic [AW-1:0]                   lo_q, lo_d;
  logic [AW-1:0]                   hi_q, hi_d;
  logic [AW-1:0]                   mid_q, mid_d;
  logic [apss_pkg::AgeBits-1:0]    bound_q, bound_d;
  apss_pkg::result_t               hold_q, hold_d;
  logic                            out_valid_q, out_valid_d;
  apss_pkg::result_t               out_q, out_d;

  logic                            accept;
  logic                            out_free;
  logic                            finish;
  apss_pkg::result_t               fin_res;
  logic [LW-1:0]                   len_m1;
  logic [AW-1:0]                   top_idx;
  logic [NODE_BITS+IB-1:0]         wr_node_ext;
  logic [NODE_BITS+IB-1:0]         rd_node_ext;
  logic [apss_pkg::AgeBits-1:0]    rd_age;
  logic [AW-1:0]                   lo_n, hi_n;

  assign in_ready_o  = (state_q == apss_pkg::StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign len_m1      = len_q - LW'(1);
  assign top_idx     = len_m1[AW-1:0];

  // node field resized to the stored width and back
  assign wr_node_ext = {{NODE_BITS{1'b0}}, in_node_i};
  assign rd_node_ext = {{IB{1'b0}}, mem_rdata_i[NODE_BITS-1:0]};
  assign rd_age      = mem_rdata_i[apss_pkg::AgeBits+NODE_BITS-1:NODE_BITS];

  assign mem_wdata_o = {in_age_i, wr_node_ext[NODE_BITS-1:0]};
  assign mem_waddr_o = len_q[AW-1:0];

  // search step: narrow the range from the entry read last cycle
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (rd_age > bound_q) begin
      lo_n = mid_q + AW'(1);
    end else begin
      hi_n = mid_q;
    end
  end

  // next state, memory requests and finishing results
  always_comb begin
    state_d        = state_q;
    len_d          = len_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    mid_d          = mid_q;
    bound_d        = bound_q;
    hold_d         = hold_q;
    mem_we_o       = 1'b0;
    mem_re_o       = 1'b0;
    mem_raddr_o    = mid_q;
    finish         = 1'b0;
    fin_res.node   = '0;
    fin_res.status = apss_pkg::StatOk;

    case (state_q)
      apss_pkg::StIdle: begin
        if (accept) begin
          case (in_func_i)
            apss_pkg::FuncPush: begin
              finish = 1'b1;
              if (len_q == LW'(MAX_DEPTH)) begin
                fin_res.status = apss_pkg::StatFull;
              end else begin
                mem_we_o = 1'b1;
                len_d    = len_q + LW'(1);
              end
            end
            apss_pkg::FuncPop: begin
              finish = 1'b1;
              if (len_q == '0) begin
                fin_res.status = apss_pkg::StatEmptyPop;
              end else begin
                len_d = len_m1;
              end
            end
            apss_pkg::FuncQuery: begin
              if (len_q == '0) begin
                finish         = 1'b1;
                fin_res.status = apss_pkg::StatEmptyQuery;
              end else begin
                bound_d  = in_bound_i;
                lo_d     = '0;
                hi_d     = top_idx;
                mem_re_o = 1'b1;
                if (top_idx == '0) begin
                  mem_raddr_o = top_idx;
                  state_d     = apss_pkg::StFetch;
                end else begin
                  mid_d       = top_idx >> 1;
                  mem_raddr_o = mid_d;
                  state_d     = apss_pkg::StSearch;
                end
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      apss_pkg::StSearch: begin
        lo_d     = lo_n;
        hi_d     = hi_n;
        mem_re_o = 1'b1;
        if (lo_n < hi_n) begin
          mid_d       = lo_n + ((hi_n - lo_n) >> 1);
          mem_raddr_o = mid_d;
        end else begin
          mem_raddr_o = hi_n;
          state_d     = apss_pkg::StFetch;
        end
      end
      apss_pkg::StFetch: begin
        finish       = 1'b1;
        fin_res.node = rd_node_ext[IB-1:0];
        state_d      = apss_pkg::StIdle;
      end
      apss_pkg::StHold: begin
        if (out_free) begin
          state_d = apss_pkg::StIdle;
        end
      end
      default: begin
        state_d = apss_pkg::StIdle;
      end
    endcase

    // a result that finds the output register busy waits in the hold slot
    if (finish && !out_free) begin
      hold_d  = fin_res;
      state_d = apss_pkg::StHold;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish && out_free) begin
      out_valid_d = 1'b1;
      out_d       = fin_res;
    end else if ((state_q == apss_pkg::StHold) && out_free) begin
      out_valid_d = 1'b1;
      out_d       = hold_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apss_pkg::StIdle;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // search and payload registers
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    bound_q <= bound_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== design/apss_checker.sv =====
// ----------------------------------------------------------------------------
// apss_checker
// Port-level checks of the path stack search unit, bound to the top level.
// ----------------------------------------------------------------------------
module apss_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid_i,
  input logic                                 s_axis_tready_o,
  input logic [apss_pkg::InDataBits-1:0]      s_axis_tdata_i,
  input logic [apss_pkg::FuncBits-1:0]        s_axis_tuser_i,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [apss_pkg::OutDataBits-1:0]     m_axis_tdata_o,
  input logic [apss_pkg::StatusBits-1:0]      m_axis_tuser_o
);

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result item dropped while stalled");

  // a waiting result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result item changed while stalled");

  // non-query items answer in the next cycle when the output is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o &&
      (s_axis_tuser_i != apss_pkg::FuncQuery) |=> m_axis_tvalid_o)
    else $error("push or pop result late");

  // error results carry no node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != apss_pkg::StatOk) |->
      (m_axis_tdata_o == '0))
    else $error("error result with nonzero node");

endmodule

bind ancestor_path_stack_search_unit apss_checker u_apss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
